// File: sv/sorted_list_engine_defines.svh
// assertion macros used by the checker file
`ifndef SORTED_LIST_ENGINE_DEFINES_SVH
`define SORTED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sle_pkg.sv
// types and constants of the sorted list engine
package sle_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_W      = 5;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REVERSE = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_REM,
    S_REV_RB,
    S_REV_WA,
    S_REV_WB,
    S_READ,
    S_RESULT
  } state_e;

  typedef struct packed {
    status_e                     status;
    logic signed [VALUE_W-1:0]   value;
    logic                        last;
    logic [COUNT_W-1:0]          count;
  } result_t;

endpackage

// File: sv/sorted_list_engine.sv
// sorted list engine top level: sequencer, compare unit and result register
//
//   chan dir  handshake               payload
//   in   sink in_valid_i/in_ready_o   opcode_i, item_value_i
//   out  src  out_valid_o/out_ready_i status_o, entry_value_o, last_of_run_o, entry_count_o
//
// during an insert or remove scan one entry per cycle passes the compare unit and the table's one read port
// insert and remove scan every entry, then report; reverse swaps front and back entries pair by pair
// read out: one entry per cycle while out_ready_i is high
// dropped insert on a full list, or remove or read out on an empty list: result only
// in_ready_o is high only between items; a stalled output holds the sequencer
// reset (rst_ni low, asynchronous) empties the list; the table itself is not cleared
module sorted_list_engine #(
  parameter int unsigned CAPACITY = sle_pkg::DEF_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          opcode_i,
  input  logic signed [sle_pkg::VALUE_W-1:0]  item_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic signed [sle_pkg::VALUE_W-1:0]  entry_value_o,
  output logic                                last_of_run_o,
  output logic [sle_pkg::COUNT_W-1:0]         entry_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  sle_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   b_q, b_d;
  logic            found_q, found_d;
  logic signed [sle_pkg::VALUE_W-1:0] carry_q, carry_d;
  logic signed [sle_pkg::VALUE_W-1:0] val_q, val_d;
  sle_pkg::status_e status_q, status_d;

  logic             out_valid_q;
  sle_pkg::result_t res_q;
  sle_pkg::result_t emit_res;
  logic             emit;
  logic             slot_free;
  logic             in_accept;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic signed [sle_pkg::VALUE_W-1:0] mem_wdata;
  logic signed [sle_pkg::VALUE_W-1:0] mem_rdata;

  logic [AW-1:0]   a_cur, a_next, b_next;
  logic            rev_more;
  logic            rd_last;
  logic            scan_end;

  sle_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == sle_pkg::S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  // reverse walks a from the front and b from the back
  assign a_cur    = idx_q[AW-1:0];
  assign a_next   = a_cur + 1'b1;
  assign b_next   = b_q - 1'b1;
  assign rev_more = (a_next < b_next);
  assign rd_last  = (idx_q == count_q - CW'(1));
  assign scan_end = (idx_q == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sle_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (sle_pkg::op_e'(opcode_i))
            sle_pkg::OP_INSERT:
              state_d = (count_q == CW'(CAPACITY)) ? sle_pkg::S_RESULT : sle_pkg::S_INS;
            sle_pkg::OP_REMOVE:
              state_d = (count_q == '0) ? sle_pkg::S_RESULT : sle_pkg::S_REM;
            sle_pkg::OP_REVERSE:
              state_d = (count_q < CW'(2)) ? sle_pkg::S_RESULT : sle_pkg::S_REV_RB;
            sle_pkg::OP_READ:
              state_d = (count_q == '0) ? sle_pkg::S_RESULT : sle_pkg::S_READ;
            default: state_d = sle_pkg::S_IDLE;
          endcase
        end
      end
      sle_pkg::S_INS,
      sle_pkg::S_REM: begin
        if (scan_end) begin
          state_d = sle_pkg::S_RESULT;
        end
      end
      sle_pkg::S_REV_RB: state_d = sle_pkg::S_REV_WA;
      sle_pkg::S_REV_WA: state_d = sle_pkg::S_REV_WB;
      sle_pkg::S_REV_WB: state_d = rev_more ? sle_pkg::S_REV_RB : sle_pkg::S_RESULT;
      sle_pkg::S_READ: begin
        if (slot_free && rd_last) begin
          state_d = sle_pkg::S_IDLE;
        end
      end
      sle_pkg::S_RESULT: begin
        if (slot_free) begin
          state_d = sle_pkg::S_IDLE;
        end
      end
      default: state_d = sle_pkg::S_IDLE;
    endcase
  end

  // datapath and table control
  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    b_d       = b_q;
    found_d   = found_q;
    carry_d   = carry_q;
    val_d     = val_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = a_cur;
    mem_wdata = carry_q;
    mem_raddr = '0;
    emit      = 1'b0;
    emit_res.status = sle_pkg::ST_OK;
    emit_res.value  = '0;
    emit_res.last   = 1'b1;
    emit_res.count  = sle_pkg::COUNT_W'(count_q);

    unique case (state_q)
      sle_pkg::S_IDLE: begin
        // front entry is read every idle cycle so a scan starts with it
        mem_raddr = '0;
        if (in_accept) begin
          idx_d    = '0;
          found_d  = 1'b0;
          val_d    = item_value_i;
          b_d      = AW'(count_q - CW'(1));
          status_d = sle_pkg::ST_OK;
          unique case (sle_pkg::op_e'(opcode_i))
            sle_pkg::OP_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                status_d = sle_pkg::ST_FULL;
              end
            end
            sle_pkg::OP_REMOVE,
            sle_pkg::OP_READ: begin
              if (count_q == '0) begin
                status_d = sle_pkg::ST_EMPTY;
              end
            end
            sle_pkg::OP_REVERSE: status_d = sle_pkg::ST_OK;
            default: status_d = sle_pkg::ST_OK;
          endcase
        end
      end

      sle_pkg::S_INS: begin
        mem_raddr = AW'(idx_q + CW'(1));
        if (scan_end) begin
          mem_we    = 1'b1;
          mem_wdata = found_q ? carry_q : val_q;
          count_d   = count_q + CW'(1);
          status_d  = sle_pkg::ST_OK;
        end else begin
          // entries from the insert point on ripple up by one
          if (found_q) begin
            mem_we    = 1'b1;
            mem_wdata = carry_q;
            carry_d   = mem_rdata;
          end else if (val_q <= mem_rdata) begin
            mem_we    = 1'b1;
            mem_wdata = val_q;
            carry_d   = mem_rdata;
            found_d   = 1'b1;
          end
          idx_d = idx_q + CW'(1);
        end
      end

      sle_pkg::S_REM: begin
        mem_raddr = AW'(idx_q + CW'(1));
        if (scan_end) begin
          if (found_q) begin
            count_d  = count_q - CW'(1);
            status_d = sle_pkg::ST_OK;
          end else begin
            status_d = sle_pkg::ST_NOTFOUND;
          end
        end else begin
          // after the match every entry moves down by one
          if (found_q) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(idx_q - CW'(1));
            mem_wdata = mem_rdata;
          end else if (mem_rdata == val_q) begin
            found_d = 1'b1;
          end
          idx_d = idx_q + CW'(1);
        end
      end

      sle_pkg::S_REV_RB: begin
        mem_raddr = b_q;
        carry_d   = mem_rdata;
      end

      sle_pkg::S_REV_WA: begin
        mem_raddr = b_q;
        mem_we    = 1'b1;
        mem_waddr = a_cur;
        mem_wdata = mem_rdata;
      end

      sle_pkg::S_REV_WB: begin
        mem_raddr = a_next;
        mem_we    = 1'b1;
        mem_waddr = b_q;
        mem_wdata = carry_q;
        idx_d     = idx_q + CW'(1);
        b_d       = b_next;
      end

      sle_pkg::S_READ: begin
        emit            = 1'b1;
        emit_res.status = sle_pkg::ST_OK;
        emit_res.value  = mem_rdata;
        emit_res.last   = rd_last;
        // read address moves on only when the current entry leaves
        if (slot_free) begin
          mem_raddr = AW'(idx_q + CW'(1));
          idx_d     = idx_q + CW'(1);
        end else begin
          mem_raddr = a_cur;
        end
      end

      sle_pkg::S_RESULT: begin
        emit            = 1'b1;
        emit_res.status = status_q;
      end

      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sle_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (emit && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    b_q      <= b_d;
    found_q  <= found_d;
    carry_q  <= carry_d;
    val_q    <= val_d;
    status_q <= status_d;
    if (emit && slot_free) begin
      res_q <= emit_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign entry_value_o = res_q.value;
  assign last_of_run_o = res_q.last;
  assign entry_count_o = res_q.count;

endmodule

// File: sv/sle_mem.sv
// entry table: one write port, one read port with registered read data
module sle_mem #(
  parameter int unsigned DEPTH = sle_pkg::DEF_CAPACITY,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [AW-1:0]                       waddr_i,
  input  logic signed [sle_pkg::VALUE_W-1:0]  wdata_i,
  input  logic [AW-1:0]                       raddr_i,
  output logic signed [sle_pkg::VALUE_W-1:0]  rdata_o
);

  logic signed [sle_pkg::VALUE_W-1:0] mem [DEPTH];
  logic signed [sle_pkg::VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sle_checker.sv
// port-level checks of the sorted list engine, bound to the top level
`include "sorted_list_engine_defines.svh"

module sle_checker #(
  parameter int unsigned CAPACITY = sle_pkg::DEF_CAPACITY
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [1:0]                          opcode_i,
  input logic signed [sle_pkg::VALUE_W-1:0]  item_value_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [1:0]                          status_o,
  input logic signed [sle_pkg::VALUE_W-1:0]  entry_value_o,
  input logic                                last_of_run_o,
  input logic [sle_pkg::COUNT_W-1:0]         entry_count_o
);

  // a dropped insert only happens with the table full
  `SLE_ASSERT_IMPL(a_full_at_cap, out_valid_o && (status_o == sle_pkg::ST_FULL), entry_count_o == sle_pkg::COUNT_W'(CAPACITY), "full status with table not full")

  `SLE_ASSERT_IMPL(a_empty_count, out_valid_o && (status_o == sle_pkg::ST_EMPTY), entry_count_o == '0, "empty status with entries held")

  // only read out produces non-final results, and those are always ok
  `SLE_ASSERT_IMPL(a_mid_ok, out_valid_o && !last_of_run_o, status_o == sle_pkg::ST_OK, "non-final result with error status")

  `SLE_ASSERT_IMPL(a_err_zero, out_valid_o && (status_o != sle_pkg::ST_OK), entry_value_o == '0, "error result carries a value")

  // every accepted item takes the sequencer out of idle, so in_ready_o drops
  `SLE_ASSERT_NEXT(a_busy_after, in_valid_i && in_ready_o, !in_ready_o, "ready right after an accepted item")

endmodule

bind sorted_list_engine sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (.*);
